>>> sv/ssmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmt_pkg
// shared types and codes of the sparse-set membership table
// ----------------------------------------------------------------------------
package ssmt_pkg;

    localparam int IDX_W = 8;
    localparam int POS_W = 8;
    localparam int CNT_W = 8;
    localparam int MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_ADD      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CONTAINS = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ_AT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  object_index;
        logic [POS_W-1:0]  position;
    } ssmt_in_t;

    typedef struct packed {
        logic              ok;
        logic [IDX_W-1:0]  member_index;
        logic [CNT_W-1:0]  member_count;
    } ssmt_out_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ssmt_state_t;

endpackage

>>> sv/ssmt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmt_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ssmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/sparse_set_membership_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_set_membership_table
// sparse-set membership table over object indices 1..SLOTS-1
//
// usage:
//   s_ channel takes one command beat (mode, object_index, position)
//   m_ channel returns exactly one result beat per command (ok,
//   member_index, member_count), in command order
//   each command reads the sparse map and the dense list at its accept edge
//   and commits the read-modify-write in the execute state once the result
//   register is free, so the result beat goes valid at that commit; a new
//   command is taken only after the last one has committed, since the
//   registered read of the two rams comes before each commit; clear writes no
//   ram entry since map entries carry reset-cleared valid flags
//   s_ready drops while a command is in flight
//   if the receiver stalls, the finished result waits in the output
//   register; one more command is accepted and holds before commit
//   reset empties the set at once (count zero, all valid flags cleared);
//   no sweep of the rams is needed
// ----------------------------------------------------------------------------
module sparse_set_membership_table import ssmt_pkg::*; #(
    parameter int SLOTS = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ssmt_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output ssmt_out_t m_data
);

    localparam int MAP_D = (SLOTS < (1 << IDX_W)) ? SLOTS : (1 << IDX_W);
    localparam int MAW   = $clog2(MAP_D);

    ssmt_state_t      state_reg, state_next;
    ssmt_in_t         req_reg, req_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [MAP_D-1:0] valid_reg, valid_next;
    logic             m_valid_reg, m_valid_next;
    ssmt_out_t        m_data_reg, m_data_next;

    logic             accept;
    logic             out_free;
    logic             commit;

    logic             map_we, dense_we;
    logic [MAW-1:0]   map_waddr, dense_waddr;
    logic [CNT_W-1:0] map_wdata;
    logic [IDX_W-1:0] dense_wdata;
    logic [MAW-1:0]   map_raddr, dense_raddr;
    logic [CNT_W-1:0] map_q;
    logic [IDX_W-1:0] dense_q;

    logic [CNT_W-1:0] cnt_m1;
    logic [MAW-1:0]   idx_addr;
    logic [MAW-1:0]   last_addr;
    logic             idx_ok;
    logic             is_mem;
    logic             ok;
    logic [IDX_W-1:0] member;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_EXEC) && out_free;
    assign cnt_m1   = count_reg - CNT_W'(1);

    // issue reads at accept
    assign map_raddr   = s_data.object_index[MAW-1:0];
    assign dense_raddr = (s_data.mode == MODE_READ_AT) ? s_data.position[MAW-1:0]
                                                       : cnt_m1[MAW-1:0];

    ssmt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAP_D)
    ) u_map (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (accept),
        .raddr (map_raddr),
        .rdata (map_q)
    );

    ssmt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAP_D)
    ) u_dense (
        .aclk  (aclk),
        .we    (dense_we),
        .waddr (dense_waddr),
        .wdata (dense_wdata),
        .re    (accept),
        .raddr (dense_raddr),
        .rdata (dense_q)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_EXEC: s_ready = 1'b0;
            default: s_ready = 1'b0;
        endcase
    end

    // execute and write back
    always_comb begin
        idx_addr    = req_reg.object_index[MAW-1:0];
        last_addr   = dense_q[MAW-1:0];
        idx_ok      = ({24'd0, req_reg.object_index} < SLOTS);
        is_mem      = idx_ok && valid_reg[idx_addr];
        ok          = 1'b0;
        member      = '0;
        count_next  = count_reg;
        valid_next  = valid_reg;
        map_we      = 1'b0;
        map_waddr   = idx_addr;
        map_wdata   = count_reg;
        dense_we    = 1'b0;
        dense_waddr = count_reg[MAW-1:0];
        dense_wdata = req_reg.object_index;
        case (req_reg.mode)
            MODE_ADD: begin
                if (req_reg.object_index != '0 && idx_ok && !is_mem) begin
                    ok                   = 1'b1;
                    map_we               = commit;
                    dense_we             = commit;
                    valid_next[idx_addr] = 1'b1;
                    count_next           = count_reg + CNT_W'(1);
                end
            end
            MODE_DELETE: begin
                if (is_mem && count_reg != '0) begin
                    ok                   = 1'b1;
                    dense_we             = commit;
                    dense_waddr          = map_q[MAW-1:0];
                    dense_wdata          = dense_q;
                    map_we               = commit;
                    map_waddr            = last_addr;
                    map_wdata            = map_q;
                    valid_next[idx_addr] = 1'b0;
                    count_next           = cnt_m1;
                end
            end
            MODE_CONTAINS: begin
                ok = is_mem;
            end
            MODE_READ_AT: begin
                if (req_reg.position < count_reg) begin
                    ok     = 1'b1;
                    member = dense_q;
                end
            end
            MODE_CLEAR: begin
                ok         = 1'b1;
                valid_next = '0;
                count_next = '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    // request capture and result register
    always_comb begin
        req_next     = accept ? s_data : req_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (commit) begin
            m_valid_next             = 1'b1;
            m_data_next.ok           = ok;
            m_data_next.member_index = member;
            m_data_next.member_count = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (commit) begin
                count_reg <= count_next;
                valid_reg <= valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> sv/ssmt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmt_checker
// port-level checks of the sparse-set membership table
// ----------------------------------------------------------------------------
module ssmt_checker import ssmt_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input ssmt_out_t m_data
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    // one command in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command beat accepted while another in flight");

    // a member index is only reported by a successful read
    a_member_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.member_index != '0 |-> m_data.ok)
        else $error("member index reported on failed command");

endmodule

bind sparse_set_membership_table ssmt_checker u_ssmt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
